>>> sv/cce_pkg.sv
// shared types and constants for the causal convolution energy block
// no dependencies; imported by cce_mac and causal_convolution_energy

package cce_pkg;

    // default store depth (samples per bunch at most)
    localparam int MAX_LEN_DEF = 256;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 32;
    localparam int BLEN_W   = 9;
    localparam int POS_W    = 8;
    localparam int ENERGY_W = 32;
    localparam int PROD_W   = 2 * SAMPLE_W;

    // configuration register indexes
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_BLEN = 1'b1;

    // control from the sequencer to the mac datapath
    typedef struct packed {
        logic wr;    // store the new samples
        logic clr;   // clear the accumulator
        logic rd;    // issue one read pair
    } t_mac_ctl;

endpackage

>>> sv/cce_mac.sv
// sample stores and multiply-accumulate datapath
// depends on cce_pkg; instantiated by causal_convolution_energy

module cce_mac #(
    parameter int MAX_LEN = cce_pkg::MAX_LEN_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  cce_pkg::t_mac_ctl                             i_ctl,
    input  logic [$clog2(MAX_LEN)-1:0]                    i_wr_addr,
    input  logic signed [cce_pkg::SAMPLE_W-1:0]           i_wake,
    input  logic signed [cce_pkg::SAMPLE_W-1:0]           i_profile,
    input  logic [$clog2(MAX_LEN)-1:0]                    i_wake_addr,
    input  logic [$clog2(MAX_LEN)-1:0]                    i_prof_addr,
    output logic signed [cce_pkg::PROD_W+$clog2(MAX_LEN)-1:0] o_acc,
    output logic                                          o_busy
);
    import cce_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int ACC_W = PROD_W + IDX_W;

    logic signed [SAMPLE_W-1:0] r_wake_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] r_prof_mem [MAX_LEN];
    logic signed [SAMPLE_W-1:0] r_wake_q;
    logic signed [SAMPLE_W-1:0] r_prof_q;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_q_vld;
    logic                       r_prod_vld;

    // sample stores: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_wake_mem[i_wr_addr] <= i_wake;
            r_prof_mem[i_wr_addr] <= i_profile;
        end
        if (i_ctl.rd) begin
            r_wake_q <= r_wake_mem[i_wake_addr];
            r_prof_q <= r_prof_mem[i_prof_addr];
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld    <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_q_vld    <= i_ctl.rd;
            r_prod_vld <= r_q_vld;
        end
    end

    // product stage then accumulate
    always_ff @(posedge i_clk) begin
        if (r_q_vld) begin
            r_prod <= r_wake_q * r_prof_q;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_q_vld | r_prod_vld;

endmodule

>>> sv/causal_convolution_energy.sv
// causal convolution energy block: the result for position p is formed by one
// multiply-accumulate per cycle over the two sample memories, then scaled, rounded and
// saturated; a new input beat is taken only in the idle state, after the last result
// is registered; a waiting result does not block the next input beat
// synchronous active-low reset clears control state, gain to 0, length to 256
// depends on cce_pkg and cce_mac

module causal_convolution_energy #(
    parameter int MAX_LEN = cce_pkg::MAX_LEN_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [cce_pkg::SAMPLE_W-1:0]   i_wake_sample,
    input  logic signed [cce_pkg::SAMPLE_W-1:0]   i_profile_sample,
    input  logic                                  i_restart,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [cce_pkg::ENERGY_W-1:0]   o_energy,
    output logic [cce_pkg::POS_W-1:0]             o_position,
    output logic                                  o_last
);
    import cce_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int ACC_W = PROD_W + IDX_W;
    localparam int LO_W  = ACC_W - ACC_W / 2;
    localparam int OP_W  = LO_W + 1;
    localparam int MP_W  = OP_W + GAIN_W;
    localparam int FW    = 2 * LO_W + GAIN_W + 2;
    localparam logic signed [FW-1:0] RND = FW'(64'sd536870912);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MAC    = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_SCL_LO = 6'b001000,
        S_SCL_HI = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                   r_state, n_state;
    logic signed [GAIN_W-1:0] r_gain;
    logic [BLEN_W-1:0]        r_blen;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [IDX_W-1:0]         r_p;
    logic [IDX_W-1:0]         r_j, n_j;
    logic                     r_item_last;
    logic signed [MP_W-1:0]   r_plo;
    logic signed [MP_W-1:0]   r_phi;
    logic                     r_out_vld, n_out_vld;
    logic signed [ENERGY_W-1:0] r_energy;
    logic [POS_W-1:0]         r_pos;
    logic                     r_last;

    t_mac_ctl                 w_ctl;
    logic signed [ACC_W-1:0]  w_acc;
    logic                     w_mac_busy;
    logic                     w_in_beat;
    logic                     w_cfg_wr;
    logic [31:0]              w_len32;
    logic [IDX_W-1:0]         w_p;
    logic                     w_is_last;
    logic signed [OP_W-1:0]   w_op;
    logic signed [MP_W-1:0]   w_mp;
    logic signed [FW-1:0]     w_sum;
    logic signed [FW-1:0]     w_shr;
    logic signed [ENERGY_W-1:0] w_sat;
    logic                     w_out_free;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_blen <= BLEN_W'(256);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_GAIN: r_gain <= pwdata;
                REG_BLEN: r_blen <= pwdata[BLEN_W-1:0];
                default:  r_gain <= r_gain;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GAIN: prdata = r_gain;
            REG_BLEN: prdata = 32'(r_blen);
            default:  prdata = '0;
        endcase
    end

    // effective length and position of the incoming item
    always_comb begin
        if (r_blen == '0) begin
            w_len32 = 32'd1;
        end else if (32'(r_blen) > 32'(MAX_LEN)) begin
            w_len32 = 32'(MAX_LEN);
        end else begin
            w_len32 = 32'(r_blen);
        end
        if (i_restart || (32'(r_idx) >= w_len32)) begin
            w_p = '0;
        end else begin
            w_p = r_idx;
        end
        w_is_last = ((32'(w_p) + 32'd1) == w_len32);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in_valid & o_in_ready;
    assign w_out_free = !r_out_vld || i_out_ready;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_j       = r_j;
        n_out_vld = r_out_vld;
        w_ctl     = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    w_ctl.wr  = 1'b1;
                    w_ctl.clr = 1'b1;
                    n_j       = '0;
                    n_idx     = w_is_last ? '0 : IDX_W'(32'(w_p) + 32'd1);
                    n_state   = S_MAC;
                end
            end
            S_MAC: begin
                w_ctl.rd = 1'b1;
                if (r_j == r_p) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!w_mac_busy) begin
                    n_state = S_SCL_LO;
                end
            end
            S_SCL_LO: n_state = S_SCL_HI;
            S_SCL_HI: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_j       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_j       <= n_j;
            r_out_vld <= n_out_vld;
        end
    end

    // per-item position and last flag
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_p         <= w_p;
            r_item_last <= w_is_last;
        end
    end

    // stores and mac
    cce_mac #(
        .MAX_LEN (MAX_LEN)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_wr_addr   (w_p),
        .i_wake      (i_wake_sample),
        .i_profile   (i_profile_sample),
        .i_wake_addr (r_j),
        .i_prof_addr (r_p - r_j),
        .o_acc       (w_acc),
        .o_busy      (w_mac_busy)
    );

    // gain multiply in two halves of the accumulator
    always_comb begin
        if (r_state == S_SCL_LO) begin
            w_op = $signed({1'b0, w_acc[LO_W-1:0]});
        end else begin
            w_op = OP_W'($signed(w_acc[ACC_W-1:LO_W]));
        end
        w_mp = w_op * r_gain;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCL_LO) begin
            r_plo <= w_mp;
        end
        if (r_state == S_SCL_HI) begin
            r_phi <= w_mp;
        end
    end

    // recombine, round half up, saturate
    always_comb begin
        w_sum = (FW'(r_phi) <<< LO_W) + FW'(r_plo) + RND;
        w_shr = w_sum >>> 30;
        if ((&w_shr[FW-1:ENERGY_W-1]) || !(|w_shr[FW-1:ENERGY_W-1])) begin
            w_sat = w_shr[ENERGY_W-1:0];
        end else if (w_shr[FW-1]) begin
            w_sat = {1'b1, {(ENERGY_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(ENERGY_W-1){1'b1}}};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_energy <= w_sat;
            r_pos    <= POS_W'(r_p);
            r_last   <= r_item_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_energy    = r_energy;
    assign o_position  = r_pos;
    assign o_last      = r_last;

    // checks
    a_drained_before_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCL_LO) |-> !w_mac_busy)
        else $error("mac pipeline not drained before scaling");

    a_beat_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == S_MAC) && (r_j == '0))
        else $error("input beat did not start the mac loop");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the done state");

    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_ctl.rd)
        else $error("memory read issued while idle");

endmodule

>>> tb/tb.sv
// self-checking testbench for causal_convolution_energy: a directed table, then
// random bunches under several gain/length settings; depends on cce_pkg and the block
`timescale 1ns / 1ps

module tb;

    import cce_pkg::*;

    localparam int    CYCLE_LIMIT   = 1_000_000;
    localparam int    SETTLE_CYCLES = 16;
    localparam int    TAIL_CYCLES   = 270;
    localparam int    HOLD_CYCLES   = 1500;
    localparam int    RAND_PHASES   = 6;
    localparam logic [2:0] GAIN_ADDR = {REG_GAIN, 2'b00};
    localparam logic [2:0] BLEN_ADDR = {REG_BLEN, 2'b00};

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [POS_W-1:0]    position;
        logic                last;
    } t_energy_beat;

    typedef enum logic [1:0] {ROW_BEAT, ROW_GAIN, ROW_BLEN} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [31:0]         cfg;
        logic [SAMPLE_W-1:0] wake;
        logic [SAMPLE_W-1:0] prof;
        logic                rst;
        logic                known;
        t_energy_beat        want;
    } t_row;

    // dut ports
    logic                       i_clk;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_wake_sample;
    logic signed [SAMPLE_W-1:0] i_profile_sample;
    logic                       i_restart;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [ENERGY_W-1:0] o_energy;
    logic [POS_W-1:0]           o_position;
    logic                       o_last;

    // predictor state: sample stores, next position and register copies
    logic signed [SAMPLE_W-1:0] wake_mem [MAX_LEN_DEF];
    logic signed [SAMPLE_W-1:0] prof_mem [MAX_LEN_DEF];
    int unsigned                next_pos = 0;
    logic signed [GAIN_W-1:0]   gain_q = '0;
    logic [BLEN_W-1:0]          blen_q = BLEN_W'(256);

    t_energy_beat pending_energy [$];
    t_energy_beat oldest;

    int  errors       = 0;
    int  beats_sent   = 0;
    int  results_seen = 0;
    int  bunch_ends   = 0;
    int  cycle_cnt    = 0;
    int  send_pct     = 0;
    int  recv_pct     = 0;
    logic hold_req    = 1'b0;

    // directed rows: typed results only where they follow at a glance
    t_row dir_table [0:27] = '{
        '{ROW_BEAT, 32'h0, 16'h7fff, 16'h7fff, 1'b0, 1'b1, '{32'h0, 8'd0, 1'b0}},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h0, 8'd1, 1'b0}},
        '{ROW_BEAT, 32'h0, 16'h1234, 16'h8000, 1'b1, 1'b1, '{32'h0, 8'd0, 1'b0}},
        '{ROW_GAIN, 32'h7fffffff, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BLEN, 32'd1, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h7fffffff, 8'd0, 1'b1}},
        '{ROW_GAIN, 32'h80000000, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h80000000, 8'd0, 1'b1}},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h7fff, 1'b0, 1'b0, '0},
        '{ROW_BLEN, 32'd2, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b1, 1'b1, '{32'h80000000, 8'd0, 1'b0}},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h80000000, 8'd1, 1'b1}},
        '{ROW_GAIN, 32'h7fffffff, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h7fffffff, 8'd0, 1'b0}},
        '{ROW_BEAT, 32'h0, 16'h8000, 16'h8000, 1'b0, 1'b1, '{32'h7fffffff, 8'd1, 1'b1}},
        '{ROW_GAIN, 32'd2, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BLEN, 32'd0, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h4000, 16'h4000, 1'b0, 1'b1, '{32'd1, 8'd0, 1'b1}},
        '{ROW_BEAT, 32'h0, 16'hc000, 16'h4000, 1'b0, 1'b1, '{32'd0, 8'd0, 1'b1}},
        '{ROW_BLEN, 32'd300, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_GAIN, 32'h01000000, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h0001, 16'h7fff, 1'b1, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'hffff, 16'h8000, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h5a5a, 16'ha5a5, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h7fff, 16'h0000, 1'b1, 1'b1, '{32'd0, 8'd0, 1'b0}},
        '{ROW_BLEN, 32'd3, 16'h0, 16'h0, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h8001, 16'h7ffe, 1'b0, 1'b0, '0},
        '{ROW_BEAT, 32'h0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0}
    };

    causal_convolution_energy i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_wake_sample    (i_wake_sample),
        .i_profile_sample (i_profile_sample),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_energy         (o_energy),
        .o_position       (o_position),
        .o_last           (o_last)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // stores both samples, then forms the causal sum, scales, rounds and saturates
    function automatic t_energy_beat predict_energy(logic signed [SAMPLE_W-1:0] w,
                                                    logic signed [SAMPLE_W-1:0] p,
                                                    logic rs);
        int unsigned         len;
        int unsigned         pos;
        logic signed [63:0]  acc;
        logic signed [127:0] scaled;
        t_energy_beat        r;
        len = (blen_q == 0) ? 1 : ((blen_q > MAX_LEN_DEF) ? MAX_LEN_DEF : blen_q);
        pos = next_pos;
        if (rs || pos >= len) pos = 0;
        wake_mem[pos] = w;
        prof_mem[pos] = p;
        acc = '0;
        for (int j = 0; j <= pos; j++) acc += wake_mem[j] * prof_mem[pos - j];
        // acc is q2.30, gain q8.24: round half up on the 30 dropped bits
        scaled = acc;
        scaled = (scaled * gain_q + 128'sd536870912) >>> 30;
        if (scaled > 128'sd2147483647) r.energy = 32'h7fffffff;
        else if (scaled < -128'sd2147483648) r.energy = 32'h80000000;
        else r.energy = scaled[31:0];
        r.position = pos[POS_W-1:0];
        r.last     = (pos + 1 == len);
        next_pos   = r.last ? 0 : pos + 1;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("tb: mismatch %s on result %0d: want %0d got %0d",
                 what, results_seen, want, got);
        errors++;
    endtask

    // one input beat; valid stays high afterwards unless the next call idles
    task automatic send_item(logic [SAMPLE_W-1:0] w, logic [SAMPLE_W-1:0] p, logic rs,
                             logic known, t_energy_beat typed);
        t_energy_beat pred;
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_wake_sample    <= w;
        i_profile_sample <= p;
        i_restart        <= rs;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pred = predict_energy(w, p, rs);
        pending_energy.push_back(known ? typed : pred);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // drop valid, wait for every pending result, then let the pipe settle
    task automatic drain(int extra);
        i_in_valid <= 1'b0;
        while (pending_energy.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // apb write: setup then access, register lands when pready is high
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (addr == GAIN_ADDR) gain_q = data;
        else blen_q = data[BLEN_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver: random back-pressure, plus one long hold on request
    initial begin : rx_drive
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // result checker against the oldest pending prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_seen++;
            if (o_last === 1'b1) bunch_ends++;
            if (pending_energy.size() == 0) begin
                report("result with nothing pending", 0, o_energy);
            end else begin
                oldest = pending_energy.pop_front();
                if (o_energy !== oldest.energy)
                    report("energy", $signed(oldest.energy), o_energy);
                if (o_position !== oldest.position)
                    report("position", oldest.position, o_position);
                if (o_last !== oldest.last)
                    report("last", oldest.last, o_last);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results pending",
                     cycle_cnt, pending_energy.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        t_row        row;
        logic [31:0] gain;
        logic [31:0] blen;
        int          count;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_in_valid       = 1'b0;
        i_wake_sample    = '0;
        i_profile_sample = '0;
        i_restart        = 1'b0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        send_pct = 26;
        recv_pct = 54;
        foreach (dir_table[r]) begin
            row = dir_table[r];
            case (row.kind)
                ROW_BEAT: send_item(row.wake, row.prof, row.rst, row.known, row.want);
                ROW_GAIN: begin
                    drain(SETTLE_CYCLES);
                    write_reg(GAIN_ADDR, row.cfg);
                end
                default: begin
                    drain(SETTLE_CYCLES);
                    write_reg(BLEN_ADDR, row.cfg);
                end
            endcase
        end

        // random bunches, one gain/length setting per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain(SETTLE_CYCLES);
            case (ph)
                0: begin gain = $urandom; blen = $urandom_range(16, 2); count = 70; end
                1: begin gain = 32'h7fffffff; blen = 1; count = 40; end
                2: begin gain = 32'h80000000; blen = 9'h1ff; count = 30; end
                3: begin
                    gain = $urandom_range(32'h0200_0000);
                    if ($urandom_range(1)) gain = -gain;
                    blen  = $urandom_range(64, 17);
                    count = 90;
                end
                4: begin gain = 32'h0001_0000; blen = 256; count = 260; end
                default: begin gain = $urandom; blen = $urandom_range(8, 2); count = 60; end
            endcase
            write_reg(GAIN_ADDR, gain);
            write_reg(BLEN_ADDR, blen);
            // receiver-heavy idling, then sender-heavy, then none
            send_pct = (ph < 2) ? 26 : (ph < 4) ? 54 : 0;
            recv_pct = (ph < 2) ? 54 : (ph < 4) ? 26 : 0;
            for (int k = 0; k < count; k++) begin
                if (ph == 0 && k == 35) drain(0);
                if (ph == 3 && k == 20) hold_req = 1'b1;
                // long bunch runs without restarts so it wraps at the top position
                send_item(rand_sample(), rand_sample(),
                          (ph != 4) && ($urandom_range(19) == 0), 1'b0, '0);
            end
        end

        drain(TAIL_CYCLES);
        $display("tb: %0d input beats (directed table and %0d gain/length settings)",
                 beats_sent, RAND_PHASES);
        $display("tb: %0d results checked, %0d bunch ends, %0d mismatches",
                 results_seen, bunch_ends, errors);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
